FILE: src/kwlts_pkg.sv
// ----------------------------------------------------------------------------
// kwlts_pkg
// Shared constants and types for the k-way loser tree select unit.
// ----------------------------------------------------------------------------
package kwlts_pkg;

	// Default number of ways in the tournament
	localparam int WAYS_DEFAULT = 8;

	// Way value width and exhaustion sentinel (largest signed value)
	localparam int VALUE_W = 32;
	localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Operation handed from front to back
	localparam int OP_W = 2;
	typedef enum logic [OP_W-1:0] {
		OP_LOAD,
		OP_BUILD,
		OP_UPDATE
	} op_t;

endpackage

FILE: src/kwlts_ram.sv
// ----------------------------------------------------------------------------
// kwlts_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module kwlts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr_a,
	output logic [WIDTH-1:0] rd_data_a,
	input  logic [AW-1:0]    rd_addr_b,
	output logic [WIDTH-1:0] rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read ports
	always_ff @(posedge clk) begin
		rd_data_a <= mem_q[rd_addr_a];
		rd_data_b <= mem_q[rd_addr_b];
	end

endmodule

FILE: src/kwlts_front.sv
// ----------------------------------------------------------------------------
// kwlts_front
// Input side: decodes the command, drops unused commands and out-of-range
// ways, and pushes valid operations into the queue.
// ----------------------------------------------------------------------------
module kwlts_front #(
	parameter int WAYS = kwlts_pkg::WAYS_DEFAULT,
	parameter int TDATA_W = 40,
	localparam int WAY_W = $clog2(WAYS),
	localparam int ENTRY_W = kwlts_pkg::OP_W + WAY_W + kwlts_pkg::VALUE_W
) (
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,
	input  logic [1:0]         s_tuser,
	input  logic               q_full,
	output logic               q_push,
	output logic [ENTRY_W-1:0] q_push_data
);

	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_BUILD  = 2'd1;
	localparam logic [1:0] CMD_UPDATE = 2'd2;

	logic [WAY_W-1:0]              way;
	logic [kwlts_pkg::VALUE_W-1:0] value;
	logic                          in_range;
	logic                          keep;
	kwlts_pkg::op_t                op;

	assign way      = s_tdata[WAY_W-1:0];
	assign value    = s_tdata[WAY_W +: kwlts_pkg::VALUE_W];
	assign in_range = ({1'b0, way} < (WAY_W+1)'(WAYS));

	// Command decode
	always_comb begin
		op   = kwlts_pkg::OP_LOAD;
		keep = 1'b0;
		unique case (s_tuser)
			CMD_LOAD: begin
				op   = kwlts_pkg::OP_LOAD;
				keep = in_range;
			end
			CMD_BUILD: begin
				op   = kwlts_pkg::OP_BUILD;
				keep = 1'b1;
			end
			CMD_UPDATE: begin
				op   = kwlts_pkg::OP_UPDATE;
				keep = in_range;
			end
			default: begin
				op   = kwlts_pkg::OP_LOAD;
				keep = 1'b0;
			end
		endcase
	end

	// Accept whenever the queue has room; dropped items just vanish
	assign s_tready    = ~q_full;
	assign q_push      = s_tvalid & s_tready & keep;
	assign q_push_data = {op, way, value};

endmodule

FILE: src/kwlts_fifo.sv
// ----------------------------------------------------------------------------
// kwlts_fifo
// Small register queue between the front and the back.
// ----------------------------------------------------------------------------
module kwlts_fifo #(
	parameter int WIDTH = 37,
	parameter int DEPTH = kwlts_pkg::QUEUE_DEPTH,
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign valid    = (count_q != '0);
	assign pop_data = entry_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: src/kwlts_back.sv
// ----------------------------------------------------------------------------
// kwlts_back
// Execution side: way value memory, loser node memory, build and replay
// sequencer (fetch node, read values, compare) and the result register.
// ----------------------------------------------------------------------------
module kwlts_back #(
	parameter int WAYS = kwlts_pkg::WAYS_DEFAULT,
	localparam int WAY_W = $clog2(WAYS),
	localparam int ENTRY_W = kwlts_pkg::OP_W + WAY_W + kwlts_pkg::VALUE_W
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_valid,
	input  logic [ENTRY_W-1:0]                  q_data,
	output logic                                q_pop,
	output logic                                res_valid,
	input  logic                                res_ready,
	output logic [WAY_W-1:0]                    res_way,
	output logic signed [kwlts_pkg::VALUE_W-1:0] res_value,
	output logic                                res_exhausted
);

	localparam int VW = kwlts_pkg::VALUE_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_READ,
		ST_EVAL,
		ST_OUT
	} state_t;

	state_t                  state_q;
	logic                    is_build_q;
	logic [WAY_W-1:0]        node_q;
	logic [WAY_W-1:0]        cand_a_q;
	logic [WAY_W-1:0]        cand_b_q;
	logic [WAY_W-1:0]        cur_way_q;
	logic signed [VW-1:0]    win_val_q;
	logic [WAYS-1:0]         val_valid_q;
	logic [WAYS-1:0]         los_valid_q;
	logic                    out_valid_q;
	logic [WAY_W-1:0]        out_way_q;
	logic signed [VW-1:0]    out_value_q;
	logic                    out_exh_q;

	// Queue head fields
	kwlts_pkg::op_t          q_op;
	logic [WAY_W-1:0]        q_way;
	logic [VW-1:0]           q_value;

	assign q_op    = kwlts_pkg::op_t'(q_data[ENTRY_W-1 -: kwlts_pkg::OP_W]);
	assign q_way   = q_data[VW +: WAY_W];
	assign q_value = q_data[VW-1:0];
	assign q_pop   = (state_q == ST_IDLE) && q_valid;

	// Children of the current node; those at or above WAYS are leaves
	logic [WAY_W:0]   child_a;
	logic [WAY_W:0]   child_b;
	logic [WAY_W:0]   leaf_a_full;
	logic [WAY_W:0]   leaf_b_full;
	logic             leaf_a;
	logic             leaf_b;

	assign child_a     = {node_q, 1'b0};
	assign child_b     = {node_q, 1'b1};
	assign leaf_a      = (child_a >= (WAY_W+1)'(WAYS));
	assign leaf_b      = (child_b >= (WAY_W+1)'(WAYS));
	assign leaf_a_full = child_a - (WAY_W+1)'(WAYS);
	assign leaf_b_full = child_b - (WAY_W+1)'(WAYS);

	// Memories
	logic             val_wr_en;
	logic [VW-1:0]    val_rd_a;
	logic [VW-1:0]    val_rd_b;
	logic [WAY_W-1:0] sel_a;
	logic [WAY_W-1:0] sel_b;
	logic             los_wr_en;
	logic [WAY_W-1:0] los_wr_data;
	logic [WAY_W-1:0] los_rd;
	logic             win_wr_en;
	logic [WAY_W-1:0] win_wr_data;
	logic [WAY_W-1:0] win_rd_a;
	logic [WAY_W-1:0] win_rd_b;

	assign val_wr_en = q_pop && (q_op == kwlts_pkg::OP_LOAD || q_op == kwlts_pkg::OP_UPDATE);

	kwlts_ram #(.WIDTH(VW), .DEPTH(WAYS)) u_val_ram (
		.clk       (clk),
		.wr_en     (val_wr_en),
		.wr_addr   (q_way),
		.wr_data   (q_value),
		.rd_addr_a (sel_a),
		.rd_data_a (val_rd_a),
		.rd_addr_b (sel_b),
		.rd_data_b (val_rd_b)
	);

	kwlts_ram #(.WIDTH(WAY_W), .DEPTH(WAYS)) u_los_ram (
		.clk       (clk),
		.wr_en     (los_wr_en),
		.wr_addr   (node_q),
		.wr_data   (los_wr_data),
		.rd_addr_a (node_q),
		.rd_data_a (los_rd),
		.rd_addr_b (node_q),
		.rd_data_b ()
	);

	// Scratch for match winners during a build
	kwlts_ram #(.WIDTH(WAY_W), .DEPTH(WAYS)) u_win_ram (
		.clk       (clk),
		.wr_en     (win_wr_en),
		.wr_addr   (node_q),
		.wr_data   (win_wr_data),
		.rd_addr_a (child_a[WAY_W-1:0]),
		.rd_data_a (win_rd_a),
		.rd_addr_b (child_b[WAY_W-1:0]),
		.rd_data_b (win_rd_b)
	);

	// Contenders of the match: children for a build, stored loser and
	// carried way for a replay (unwritten loser node reads as way zero)
	always_comb begin
		if (is_build_q) begin
			sel_a = leaf_a ? leaf_a_full[WAY_W-1:0] : win_rd_a;
			sel_b = leaf_b ? leaf_b_full[WAY_W-1:0] : win_rd_b;
		end else begin
			sel_a = los_valid_q[node_q] ? los_rd : '0;
			sel_b = cur_way_q;
		end
	end

	// Match: unwritten ways read as the sentinel, ties to the lower way
	logic signed [VW-1:0] va;
	logic signed [VW-1:0] vb;
	logic                 a_beats_b;
	logic                 b_beats_a;

	assign va        = val_valid_q[cand_a_q] ? signed'(val_rd_a) : kwlts_pkg::VALUE_MAX;
	assign vb        = val_valid_q[cand_b_q] ? signed'(val_rd_b) : kwlts_pkg::VALUE_MAX;
	assign a_beats_b = (va < vb) || ((va == vb) && (cand_a_q < cand_b_q));
	assign b_beats_a = (vb < va) || ((va == vb) && (cand_b_q < cand_a_q));

	logic [WAY_W-1:0]     next_way;
	logic signed [VW-1:0] next_val;
	logic                 out_load;

	// Winner carried upward and loser kept at the node
	always_comb begin
		if (is_build_q) begin
			next_way    = b_beats_a ? cand_b_q : cand_a_q;
			next_val    = b_beats_a ? vb : va;
			los_wr_data = b_beats_a ? cand_a_q : cand_b_q;
			los_wr_en   = (state_q == ST_EVAL);
		end else begin
			next_way    = a_beats_b ? cand_a_q : cand_b_q;
			next_val    = a_beats_b ? va : vb;
			los_wr_data = cand_b_q;
			los_wr_en   = (state_q == ST_EVAL) && a_beats_b;
		end
	end

	assign win_wr_en   = (state_q == ST_EVAL) && is_build_q;
	assign win_wr_data = next_way;
	assign out_load    = (state_q == ST_OUT) && (!out_valid_q || res_ready);

	logic [WAY_W:0] start_node;
	assign start_node = ((WAY_W+1)'(q_way) + (WAY_W+1)'(WAYS)) >> 1;

	// Sequencer, valid bits and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			is_build_q  <= 1'b0;
			node_q      <= '0;
			cand_a_q    <= '0;
			cand_b_q    <= '0;
			cur_way_q   <= '0;
			win_val_q   <= '0;
			val_valid_q <= '0;
			los_valid_q <= '0;
			out_valid_q <= 1'b0;
			out_way_q   <= '0;
			out_value_q <= '0;
			out_exh_q   <= 1'b0;
		end else begin
			if (val_wr_en) begin
				val_valid_q[q_way] <= 1'b1;
			end
			if (los_wr_en) begin
				los_valid_q[node_q] <= 1'b1;
			end
			// Result valid: set on a new load, cleared once taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && res_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						unique case (q_op)
							kwlts_pkg::OP_BUILD: begin
								is_build_q <= 1'b1;
								node_q     <= WAY_W'(WAYS - 1);
								state_q    <= ST_FETCH;
							end
							kwlts_pkg::OP_UPDATE: begin
								is_build_q <= 1'b0;
								node_q     <= start_node[WAY_W-1:0];
								cur_way_q  <= q_way;
								state_q    <= ST_FETCH;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_FETCH: begin
					state_q <= ST_READ;
				end
				ST_READ: begin
					cand_a_q <= sel_a;
					cand_b_q <= sel_b;
					state_q  <= ST_EVAL;
				end
				ST_EVAL: begin
					cur_way_q <= next_way;
					win_val_q <= next_val;
					if (node_q == WAY_W'(1)) begin
						state_q <= ST_OUT;
					end else begin
						node_q  <= is_build_q ? node_q - 1'b1 : node_q >> 1;
						state_q <= ST_FETCH;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						out_way_q   <= cur_way_q;
						out_value_q <= win_val_q;
						out_exh_q   <= (win_val_q == kwlts_pkg::VALUE_MAX);
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid     = out_valid_q;
	assign res_way       = out_way_q;
	assign res_value     = out_value_q;
	assign res_exhausted = out_exh_q;

endmodule

FILE: src/k_way_loser_tree_select_unit.sv
// From input transaction to m_tvalid, a build or an update passes the queue and
// the pop, then for each node match a node read, a value read and a compare,
// then the result load, which waits while an untaken result is held. A build
// matches every node, an update those on the way's path. A load ends at the pop.
// Throughput: one operation at a time in the back; the two-entry queue keeps
// accepting until full. Reset: ways read as the sentinel, nodes as zero.
// ----------------------------------------------------------------------------
// k_way_loser_tree_select_unit
// Loser tree over WAYS signed ways for a k-way merge, with load, build and
// update commands on a stream input and the winner on a stream output.
// ----------------------------------------------------------------------------
module k_way_loser_tree_select_unit #(
	parameter int WAYS = kwlts_pkg::WAYS_DEFAULT,
	localparam int WAY_W = $clog2(WAYS),
	localparam int IN_TDATA_W = ((WAY_W + kwlts_pkg::VALUE_W + 7) / 8) * 8,
	localparam int OUT_TDATA_W = ((WAY_W + kwlts_pkg::VALUE_W + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // way_index, leaf_value, zero pad
	input  logic [1:0]             s_tuser,  // command
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // winner_way, winner_value, zero pad
	output logic                   m_tuser   // all_exhausted
);

	localparam int ENTRY_W = kwlts_pkg::OP_W + WAY_W + kwlts_pkg::VALUE_W;

	logic                                 q_full;
	logic                                 q_push;
	logic [ENTRY_W-1:0]                   q_push_data;
	logic                                 q_valid;
	logic                                 q_pop;
	logic [ENTRY_W-1:0]                   q_data;
	logic [WAY_W-1:0]                     res_way;
	logic signed [kwlts_pkg::VALUE_W-1:0] res_value;

	kwlts_front #(.WAYS(WAYS), .TDATA_W(IN_TDATA_W)) u_front (
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_push_data (q_push_data)
	);

	kwlts_fifo #(.WIDTH(ENTRY_W), .DEPTH(kwlts_pkg::QUEUE_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (q_data)
	);

	kwlts_back #(.WAYS(WAYS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_data        (q_data),
		.q_pop         (q_pop),
		.res_valid     (m_tvalid),
		.res_ready     (m_tready),
		.res_way       (res_way),
		.res_value     (res_value),
		.res_exhausted (m_tuser)
	);

	// Result packing, lowest field first
	assign m_tdata = OUT_TDATA_W'({res_value, res_way});

endmodule
